/* hw/rtl/ssms_pkg.sv */
`default_nettype none

package ssms_pkg;

    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 6;

    localparam int MAX_STATE  = 4;
    localparam int MAX_INPUT  = 2;
    localparam int MAX_OUTPUT = 2;

    localparam int DEF_STATE_DIM  = 4;
    localparam int DEF_INPUT_DIM  = 2;
    localparam int DEF_OUTPUT_DIM = 2;
    localparam int DEF_FRAC_BITS  = 16;

    // rows: OUTPUT_DIM + STATE_DIM <= 6, terms per row: STATE_DIM + INPUT_DIM <= 6
    localparam int ROW_W  = 3;
    localparam int TERM_W = 3;
    localparam int K_W    = 2;

    localparam logic [MODE_W-1:0] MODE_COEF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             is_u;
        logic [ROW_W-1:0] row;
        logic [K_W-1:0]   k;
    } term_t;

    typedef struct packed {
        logic                     valid;
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } res_t;

endpackage

`default_nettype wire

/* hw/rtl/ssms_ram.sv */
`default_nettype none

module ssms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/ssms_seq.sv */
`default_nettype none

module ssms_seq #(
    parameter int STATE_DIM  = ssms_pkg::DEF_STATE_DIM,
    parameter int INPUT_DIM  = ssms_pkg::DEF_INPUT_DIM,
    parameter int OUTPUT_DIM = ssms_pkg::DEF_OUTPUT_DIM,
    localparam int COEF_COUNT = STATE_DIM * STATE_DIM + STATE_DIM * INPUT_DIM
                              + OUTPUT_DIM * STATE_DIM + OUTPUT_DIM * INPUT_DIM,
    localparam int AW = $clog2(COEF_COUNT)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    output logic [AW-1:0]      raddr,
    output ssms_pkg::term_t    tag
);

    import ssms_pkg::*;

    localparam int OFS_B = STATE_DIM * STATE_DIM;
    localparam int OFS_C = OFS_B + STATE_DIM * INPUT_DIM;
    localparam int OFS_D = OFS_C + OUTPUT_DIM * STATE_DIM;
    localparam int TERMS = STATE_DIM + INPUT_DIM;
    localparam int ROWS  = OUTPUT_DIM + STATE_DIM;

    typedef enum logic {
        ST_IDLE,
        ST_ISSUE
    } seq_state_t;

    seq_state_t        state_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [TERM_W-1:0] term_reg;
    logic [AW-1:0]     ptr1_reg;
    logic [AW-1:0]     ptr2_reg;
    term_t             tag_reg;

    logic              is_u;
    logic              last_term;
    logic [TERM_W-1:0] k_full;

    always_comb begin
        is_u      = term_reg >= TERM_W'(STATE_DIM);
        last_term = term_reg == TERM_W'(TERMS - 1);
        k_full    = is_u ? term_reg - TERM_W'(STATE_DIM) : term_reg;
        raddr     = is_u ? ptr2_reg : ptr1_reg;
    end

    assign tag = tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            term_reg  <= '0;
            ptr1_reg  <= '0;
            ptr2_reg  <= '0;
            tag_reg   <= '0;
        end else begin
            tag_reg.valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_ISSUE;
                        row_reg   <= '0;
                        term_reg  <= '0;
                        ptr1_reg  <= AW'(OFS_C);
                        ptr2_reg  <= AW'(OFS_D);
                    end
                end
                ST_ISSUE: begin
                    tag_reg.valid <= 1'b1;
                    tag_reg.first <= term_reg == '0;
                    tag_reg.last  <= last_term;
                    tag_reg.is_u  <= is_u;
                    tag_reg.row   <= row_reg;
                    tag_reg.k     <= k_full[K_W-1:0];
                    if (is_u) begin
                        ptr2_reg <= ptr2_reg + AW'(1);
                    end else begin
                        ptr1_reg <= ptr1_reg + AW'(1);
                    end
                    if (last_term) begin
                        term_reg <= '0;
                        row_reg  <= row_reg + ROW_W'(1);
                        // observation rows done: move on to A and B
                        if (row_reg == ROW_W'(OUTPUT_DIM - 1)) begin
                            ptr1_reg <= '0;
                            ptr2_reg <= AW'(OFS_B);
                        end
                        if (row_reg == ROW_W'(ROWS - 1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        term_reg <= term_reg + TERM_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ssms_mac.sv */
`default_nettype none

module ssms_mac #(
    parameter int OUTPUT_DIM = ssms_pkg::DEF_OUTPUT_DIM,
    parameter int FRAC_BITS  = ssms_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ssms_pkg::term_t                     tag,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  coef,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  x_vec [ssms_pkg::MAX_STATE],
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  u_vec [ssms_pkg::MAX_INPUT],
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  w_vec [ssms_pkg::MAX_STATE],
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  v_vec [ssms_pkg::MAX_OUTPUT],
    output ssms_pkg::res_t                           res
);

    import ssms_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF =
        {{(PROD_W - 1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    term_t                    tag2_reg;
    term_t                    tag3_reg;
    term_t                    tag4_reg;
    res_t                     res_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd_reg;
    logic signed [PROD_W-1:0] acc_reg;

    logic signed [DATA_W-1:0] opnd;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rnd_next;
    logic [ROW_W-1:0]         row_off;
    logic signed [DATA_W-1:0] noise;
    logic signed [PROD_W-1:0] noise_ext;
    logic signed [PROD_W-1:0] acc_next;
    res_t                     res_next;

    always_comb begin
        opnd      = tag.is_u ? u_vec[tag.k[0]] : x_vec[tag.k];
        prod_next = coef * opnd;
        rnd_next  = (prod_reg + HALF) >>> FRAC_BITS;

        row_off   = tag3_reg.row - ROW_W'(OUTPUT_DIM);
        noise     = (tag3_reg.row < ROW_W'(OUTPUT_DIM)) ? v_vec[tag3_reg.row[0]]
                                                        : w_vec[row_off[K_W-1:0]];
        noise_ext = {{(PROD_W - DATA_W){noise[DATA_W-1]}}, noise};
        acc_next  = tag3_reg.first ? noise_ext + rnd_reg : acc_reg + rnd_reg;

        res_next.valid = tag4_reg.valid && tag4_reg.last;
        res_next.row   = tag4_reg.row;
        if (acc_reg > SAT_MAX) begin
            res_next.value = SAT_MAX[DATA_W-1:0];
            res_next.sat   = 1'b1;
        end else if (acc_reg < SAT_MIN) begin
            res_next.value = SAT_MIN[DATA_W-1:0];
            res_next.sat   = 1'b1;
        end else begin
            res_next.value = acc_reg[DATA_W-1:0];
            res_next.sat   = 1'b0;
        end
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            res_reg  <= '0;
        end else begin
            tag2_reg <= tag;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            res_reg  <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
        if (tag3_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/state_space_model_step_unit.sv */
// State-space model step unit, signed fixed point with FRAC_BITS fraction bits.
// Input channel (s_*): one beat per command. Mode 0 writes coefficient s_index
// (A, B, C, D row-major) into the coefficient RAM, mode 1 writes state element
// s_index; both give no result. Mode 2 runs one step with
// u, w and v and gives one result beat on the m_* channel: y = C x + D u + v
// from the old state and the new state A x + B u + w, plus a saturation flag.
// Mode 3 and out-of-range write indexes are dropped.
// A step streams (OUTPUT_DIM + STATE_DIM) * (STATE_DIM + INPUT_DIM) products
// through one 32x32 multiplier, one per cycle, read from a single-port-read
// coefficient RAM; m_valid rises after the last row result is registered
// and the FINISH state is left. s_ready is low while a step runs.
// The result sits in an output register: the next command can be taken while
// it waits. If the receiver stalls with a result still held, a new step runs
// to completion and then holds (s_ready low) until the older result is taken.
// Reset (aresetn low, synchronous) clears the state vector and the handshake;
// coefficients are undefined until written.
`default_nettype none

module state_space_model_step_unit #(
    parameter int STATE_DIM  = ssms_pkg::DEF_STATE_DIM,
    parameter int INPUT_DIM  = ssms_pkg::DEF_INPUT_DIM,
    parameter int OUTPUT_DIM = ssms_pkg::DEF_OUTPUT_DIM,
    parameter int FRAC_BITS  = ssms_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ssms_pkg::MODE_W-1:0]         s_mode,
    input  wire logic [ssms_pkg::INDEX_W-1:0]        s_index,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_value,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_u_first,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_u_second,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_w_first,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_w_second,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_w_third,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_w_fourth,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_v_first,
    input  wire logic signed [ssms_pkg::DATA_W-1:0]  s_v_second,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ssms_pkg::DATA_W-1:0]       m_y_first,
    output logic signed [ssms_pkg::DATA_W-1:0]       m_y_second,
    output logic signed [ssms_pkg::DATA_W-1:0]       m_next_state_first,
    output logic signed [ssms_pkg::DATA_W-1:0]       m_next_state_second,
    output logic signed [ssms_pkg::DATA_W-1:0]       m_next_state_third,
    output logic signed [ssms_pkg::DATA_W-1:0]       m_next_state_fourth,
    output logic                                     m_saturated
);

    import ssms_pkg::*;

    localparam int COEF_COUNT = STATE_DIM * STATE_DIM + STATE_DIM * INPUT_DIM
                              + OUTPUT_DIM * STATE_DIM + OUTPUT_DIM * INPUT_DIM;
    localparam int AW   = $clog2(COEF_COUNT);
    localparam int ROWS = OUTPUT_DIM + STATE_DIM;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } top_state_t;

    top_state_t               state_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] x_reg      [MAX_STATE];
    logic signed [DATA_W-1:0] u_reg      [MAX_INPUT];
    logic signed [DATA_W-1:0] w_reg      [MAX_STATE];
    logic signed [DATA_W-1:0] v_reg      [MAX_OUTPUT];
    logic signed [DATA_W-1:0] y_work_reg [MAX_OUTPUT];
    logic signed [DATA_W-1:0] xn_work_reg[MAX_STATE];
    logic                     sat_work_reg;
    logic signed [DATA_W-1:0] y_out_reg  [MAX_OUTPUT];
    logic signed [DATA_W-1:0] xn_out_reg [MAX_STATE];
    logic                     sat_out_reg;

    logic                     accept;
    logic                     start;
    logic                     ram_we;
    logic                     load_out;
    logic                     last_row;
    logic [ROW_W-1:0]         res_off;
    logic [AW-1:0]            raddr;
    logic [DATA_W-1:0]        rdata;
    term_t                    tag;
    res_t                     res;

    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign start    = accept && s_mode == MODE_STEP;
    assign ram_we   = accept && s_mode == MODE_COEF && s_index < INDEX_W'(COEF_COUNT);
    assign load_out = state_reg == ST_FINISH && (!m_valid_reg || m_ready);
    assign last_row = res.valid && res.row == ROW_W'(ROWS - 1);
    assign res_off  = res.row - ROW_W'(OUTPUT_DIM);

    ssms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (COEF_COUNT)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_index[AW-1:0]),
        .wdata (s_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    ssms_seq #(
        .STATE_DIM  (STATE_DIM),
        .INPUT_DIM  (INPUT_DIM),
        .OUTPUT_DIM (OUTPUT_DIM)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .raddr   (raddr),
        .tag     (tag)
    );

    ssms_mac #(
        .OUTPUT_DIM (OUTPUT_DIM),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag     (tag),
        .coef    (rdata),
        .x_vec   (x_reg),
        .u_vec   (u_reg),
        .w_vec   (w_reg),
        .v_vec   (v_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_STATE; i++) begin
                x_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_RUN;
                    end else if (accept && s_mode == MODE_STATE
                                 && s_index < INDEX_W'(STATE_DIM)) begin
                        x_reg[s_index[K_W-1:0]] <= s_value;
                    end
                end
                ST_RUN: begin
                    if (last_row) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (load_out) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b1;
                        x_reg       <= xn_work_reg;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            u_reg        <= '{s_u_first, s_u_second};
            w_reg        <= '{s_w_first, s_w_second, s_w_third, s_w_fourth};
            v_reg        <= '{s_v_first, s_v_second};
            sat_work_reg <= 1'b0;
            for (int i = 0; i < MAX_OUTPUT; i++) begin
                y_work_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_STATE; i++) begin
                xn_work_reg[i] <= '0;
            end
        end else if (res.valid) begin
            sat_work_reg <= sat_work_reg | res.sat;
            if (res.row < ROW_W'(OUTPUT_DIM)) begin
                y_work_reg[res.row[0]] <= res.value;
            end else begin
                xn_work_reg[res_off[K_W-1:0]] <= res.value;
            end
        end
        if (load_out) begin
            y_out_reg   <= y_work_reg;
            xn_out_reg  <= xn_work_reg;
            sat_out_reg <= sat_work_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_y_first           = y_out_reg[0];
    assign m_y_second          = y_out_reg[1];
    assign m_next_state_first  = xn_out_reg[0];
    assign m_next_state_second = xn_out_reg[1];
    assign m_next_state_third  = xn_out_reg[2];
    assign m_next_state_fourth = xn_out_reg[3];
    assign m_saturated         = sat_out_reg;

`ifndef SYNTH
    a_res_only_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> state_reg == ST_RUN)
        else $error("row result outside of a running step");

    a_tag_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tag.valid |-> state_reg == ST_RUN)
        else $error("product issued while not running a step");

    a_step_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("input taken right after a step beat");

    a_finish_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid && state_reg == ST_IDLE)
        else $error("finished step did not reach the output register");
`endif

endmodule

`default_nettype wire

/* sim/state_space_model_step_unit_test.sv */
`default_nettype none

module state_space_model_step_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssms_pkg::*;

    localparam int N_STATE  = DEF_STATE_DIM;
    localparam int N_INPUT  = DEF_INPUT_DIM;
    localparam int N_OUTPUT = DEF_OUTPUT_DIM;
    localparam int FRAC     = DEF_FRAC_BITS;

    localparam int OFS_A  = 0;
    localparam int OFS_B  = OFS_A + N_STATE * N_STATE;
    localparam int OFS_C  = OFS_B + N_STATE * N_INPUT;
    localparam int OFS_D  = OFS_C + N_OUTPUT * N_STATE;
    localparam int N_COEF = OFS_D + N_OUTPUT * N_INPUT;
    localparam int MAX_INDEX = 2 ** INDEX_W - 1;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] HALF  = 32'sh0000_8000;
    localparam logic signed [DATA_W-1:0] ONE   = 32'sh0001_0000;

    localparam int RANDOM_ITEMS = 1650;
    localparam int RELOAD_EVERY = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT_NS   = 10_000_000;

    typedef struct packed {
        logic [MODE_W-1:0]                   mode;
        logic [INDEX_W-1:0]                  index;
        logic [DATA_W-1:0]                   value;
        logic [MAX_INPUT-1:0][DATA_W-1:0]    u;
        logic [MAX_STATE-1:0][DATA_W-1:0]    w;
        logic [MAX_OUTPUT-1:0][DATA_W-1:0]   v;
    } ssm_command_t;

    typedef struct packed {
        logic [MAX_OUTPUT-1:0][DATA_W-1:0]   y;
        logic [MAX_STATE-1:0][DATA_W-1:0]    xn;
        logic                                sat;
    } step_result_t;

    class ssm_step_predictor;
        logic signed [DATA_W-1:0] coef_mem [N_COEF];
        logic signed [DATA_W-1:0] state_vec [N_STATE];
        step_result_t pending_steps [$];
        int mismatches;
        bit clipped;

        function new();
            foreach (coef_mem[i]) coef_mem[i] = '0;
            foreach (state_vec[i]) state_vec[i] = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_steps.size();
        endfunction

        // round half up to FRAC fraction bits, floor toward minus infinity
        function longint rounded_product(logic signed [DATA_W-1:0] a,
                                         logic signed [DATA_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
            return p >>> FRAC;
        endfunction

        function logic signed [DATA_W-1:0] saturate(longint s);
            if (s > SAT_MAX) begin
                clipped = 1'b1;
                return SAT_MAX[DATA_W-1:0];
            end
            if (s < SAT_MIN) begin
                clipped = 1'b1;
                return SAT_MIN[DATA_W-1:0];
            end
            return s[DATA_W-1:0];
        endfunction

        function logic signed [DATA_W-1:0] row_sum(int mat_x, int mat_u, int row,
                                                   ssm_command_t c,
                                                   logic signed [DATA_W-1:0] noise);
            longint acc;
            acc = longint'(noise);
            for (int k = 0; k < N_STATE; k++)
                acc += rounded_product(coef_mem[mat_x + row * N_STATE + k], state_vec[k]);
            for (int k = 0; k < N_INPUT; k++)
                acc += rounded_product(coef_mem[mat_u + row * N_INPUT + k], $signed(c.u[k]));
            return saturate(acc);
        endfunction

        function void note_command(ssm_command_t c);
            step_result_t r;
            logic signed [DATA_W-1:0] nxt [N_STATE];
            r = '0;
            clipped = 1'b0;
            case (c.mode)
                MODE_COEF: begin
                    if (c.index < N_COEF) coef_mem[c.index] = c.value;
                end
                MODE_STATE: begin
                    if (c.index < N_STATE) state_vec[c.index] = c.value;
                end
                MODE_STEP: begin
                    for (int i = 0; i < N_OUTPUT; i++)
                        r.y[i] = row_sum(OFS_C, OFS_D, i, c, $signed(c.v[i]));
                    for (int i = 0; i < N_STATE; i++)
                        nxt[i] = row_sum(OFS_A, OFS_B, i, c, $signed(c.w[i]));
                    for (int i = 0; i < N_STATE; i++) begin
                        state_vec[i] = nxt[i];
                        r.xn[i] = nxt[i];
                    end
                    r.sat = clipped;
                    pending_steps.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want) begin
                if (mismatches < MAX_REPORTS)
                    $display("mismatch %s: expected %h, got %h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            if (pending_steps.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("result beat with no step pending: y %h %h",
                             got.y[0], got.y[1]);
                mismatches++;
                return;
            end
            want = pending_steps.pop_front();
            for (int i = 0; i < MAX_OUTPUT; i++)
                compare_field($sformatf("y[%0d]", i), want.y[i], got.y[i]);
            for (int i = 0; i < MAX_STATE; i++)
                compare_field($sformatf("next_state[%0d]", i), want.xn[i], got.xn[i]);
            compare_field("saturated", DATA_W'(want.sat), DATA_W'(got.sat));
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                       s_valid    = 1'b0;
    logic                       s_ready;
    logic [MODE_W-1:0]          s_mode     = '0;
    logic [INDEX_W-1:0]         s_index    = '0;
    logic signed [DATA_W-1:0]   s_value    = '0;
    logic signed [DATA_W-1:0]   s_u_first  = '0;
    logic signed [DATA_W-1:0]   s_u_second = '0;
    logic signed [DATA_W-1:0]   s_w_first  = '0;
    logic signed [DATA_W-1:0]   s_w_second = '0;
    logic signed [DATA_W-1:0]   s_w_third  = '0;
    logic signed [DATA_W-1:0]   s_w_fourth = '0;
    logic signed [DATA_W-1:0]   s_v_first  = '0;
    logic signed [DATA_W-1:0]   s_v_second = '0;

    logic                       m_valid;
    logic                       m_ready    = 1'b0;
    logic signed [DATA_W-1:0]   m_y_first;
    logic signed [DATA_W-1:0]   m_y_second;
    logic signed [DATA_W-1:0]   m_next_state_first;
    logic signed [DATA_W-1:0]   m_next_state_second;
    logic signed [DATA_W-1:0]   m_next_state_third;
    logic signed [DATA_W-1:0]   m_next_state_fourth;
    logic                       m_saturated;

    ssm_step_predictor sb = new();

    int burst_left = 0;
    int rx_left    = 0;
    int rx_kind    = 0;
    int a_bits     = 15;
    int bcd_bits   = 17;
    bit mixed_profile = 1'b0;

    ssm_command_t seen_cmd;
    step_result_t seen_result;

    state_space_model_step_unit u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_kind = $urandom_range(0, 3);
            rx_left = $urandom_range(1, 60);
        end
        rx_left--;
        case (rx_kind)
            0: m_ready = 1'b1;
            1: m_ready = 1'($urandom_range(0, 1));
            2: m_ready = 1'b0;
            default: m_ready = ($urandom_range(0, 3) != 0);
        endcase
    end

    // result checked first: it always belongs to an older step
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_result.y[0]  = m_y_first;
                seen_result.y[1]  = m_y_second;
                seen_result.xn[0] = m_next_state_first;
                seen_result.xn[1] = m_next_state_second;
                seen_result.xn[2] = m_next_state_third;
                seen_result.xn[3] = m_next_state_fourth;
                seen_result.sat   = m_saturated;
                sb.check_result(seen_result);
            end
            if (s_valid && s_ready) begin
                seen_cmd.mode  = s_mode;
                seen_cmd.index = s_index;
                seen_cmd.value = s_value;
                seen_cmd.u[0]  = s_u_first;
                seen_cmd.u[1]  = s_u_second;
                seen_cmd.w[0]  = s_w_first;
                seen_cmd.w[1]  = s_w_second;
                seen_cmd.w[2]  = s_w_third;
                seen_cmd.w[3]  = s_w_fourth;
                seen_cmd.v[0]  = s_v_first;
                seen_cmd.v[1]  = s_v_second;
                sb.note_command(seen_cmd);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_word(int nbits);
        logic signed [DATA_W-1:0] r;
        if (nbits <= 0) begin
            case ($urandom_range(0, 5))
                0: return W_MIN;
                1: return W_MAX;
                2: return '0;
                3: return -1;
                4: return HALF;
                default: return -HALF;
            endcase
        end
        r = $urandom;
        return r >>> (DATA_W - nbits);
    endfunction

    function automatic int field_bits();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 17;
        if (r < 70) return 21;
        if (r < 85) return 32;
        if (r < 95) return 26;
        return 0;
    endfunction

    function automatic logic signed [DATA_W-1:0] coef_word(int idx);
        if (mixed_profile) return rand_word(field_bits());
        return rand_word(idx < OFS_B ? a_bits : bcd_bits);
    endfunction

    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 40);
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 4);
        if (r < 9) return $urandom_range(5, 20);
        return $urandom_range(21, 60);
    endfunction

    function automatic ssm_command_t write_cmd(logic [MODE_W-1:0] mode, int idx,
                                               logic signed [DATA_W-1:0] val);
        ssm_command_t c;
        c.mode  = mode;
        c.index = idx[INDEX_W-1:0];
        c.value = val;
        for (int k = 0; k < MAX_INPUT; k++) c.u[k] = $urandom;
        for (int k = 0; k < MAX_STATE; k++) c.w[k] = $urandom;
        for (int k = 0; k < MAX_OUTPUT; k++) c.v[k] = $urandom;
        return c;
    endfunction

    function automatic ssm_command_t step_cmd(
        logic signed [DATA_W-1:0] u0, logic signed [DATA_W-1:0] u1,
        logic signed [DATA_W-1:0] w0, logic signed [DATA_W-1:0] w1,
        logic signed [DATA_W-1:0] w2, logic signed [DATA_W-1:0] w3,
        logic signed [DATA_W-1:0] v0, logic signed [DATA_W-1:0] v1);
        ssm_command_t c;
        c.mode  = MODE_STEP;
        c.index = INDEX_W'($urandom);
        c.value = $urandom;
        c.u[0] = u0;
        c.u[1] = u1;
        c.w[0] = w0;
        c.w[1] = w1;
        c.w[2] = w2;
        c.w[3] = w3;
        c.v[0] = v0;
        c.v[1] = v1;
        return c;
    endfunction

    task automatic send_beat(ssm_command_t c, int gap);
        @(negedge aclk);
        s_valid    = 1'b1;
        s_mode     = c.mode;
        s_index    = c.index;
        s_value    = c.value;
        s_u_first  = c.u[0];
        s_u_second = c.u[1];
        s_w_first  = c.w[0];
        s_w_second = c.w[1];
        s_w_third  = c.w[2];
        s_w_fourth = c.w[3];
        s_v_first  = c.v[0];
        s_v_second = c.v[1];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic reload_coefficients();
        int r;
        r = $urandom_range(0, 99);
        mixed_profile = 1'b0;
        if (r < 50) begin
            a_bits = 15;
            bcd_bits = 17;
        end else if (r < 75) begin
            a_bits = 17;
            bcd_bits = 21;
        end else if (r < 85) begin
            a_bits = 24;
            bcd_bits = 32;
        end else begin
            mixed_profile = 1'b1;
        end
        for (int i = 0; i < N_COEF; i++)
            send_beat(write_cmd(MODE_COEF, i, coef_word(i)), next_gap());
    endtask

    initial begin : main_seq
        logic signed [DATA_W-1:0] coef;
        ssm_command_t c;
        int counted;
        int next_reload;
        int pick;
        int idx;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // A = I, B = D = one LSB, C picks x0 and -x3
        for (int i = 0; i < N_COEF; i++) begin
            if (i < OFS_B)
                coef = (i % (N_STATE + 1) == 0) ? ONE : '0;
            else if (i < OFS_C || i >= OFS_D)
                coef = 32'sd1;
            else if (i == OFS_C)
                coef = ONE;
            else if (i == OFS_D - 1)
                coef = -ONE;
            else
                coef = '0;
            send_beat(write_cmd(MODE_COEF, i, coef), next_gap());
        end

        // rounding at exactly half an LSB, both signs
        send_beat(step_cmd(HALF, -HALF, 0, 0, 0, 0, 0, 0), next_gap());
        send_beat(step_cmd(-HALF - 1, HALF - 1, W_MAX, W_MIN, -1, 1, W_MIN, W_MAX),
                  next_gap());
        send_beat(step_cmd(W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN),
                  next_gap());
        send_beat(write_cmd(MODE_STATE, 0, W_MIN), next_gap());
        send_beat(write_cmd(MODE_STATE, N_STATE - 1, W_MAX), next_gap());
        send_beat(write_cmd(MODE_STATE, N_STATE, 32'sd12345), next_gap());
        send_beat(write_cmd(MODE_STATE, MAX_INDEX, -1), next_gap());
        send_beat(write_cmd(MODE_COEF, 0, W_MIN), next_gap());
        send_beat(write_cmd(MODE_COEF, N_COEF - 1, W_MAX), next_gap());
        send_beat(write_cmd(MODE_COEF, N_COEF, ONE), next_gap());
        send_beat(write_cmd(MODE_COEF, MAX_INDEX, ONE), next_gap());
        send_beat(write_cmd(MODE_NONE, 0, ONE), next_gap());
        send_beat(step_cmd(0, 0, 0, 0, 0, 0, 0, 0), next_gap());
        send_beat(write_cmd(MODE_COEF, 0, ONE), next_gap());
        send_beat(write_cmd(MODE_STATE, 1, -1), next_gap());
        send_beat(write_cmd(MODE_STATE, 2, 32'sd1), next_gap());
        send_beat(step_cmd(-1, 1, -1, -1, -1, -1, -1, -1), next_gap());
        send_beat(step_cmd(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN),
                  next_gap());

        hold_until_drained();
        reload_coefficients();
        counted = N_COEF;
        next_reload = RELOAD_EVERY;

        while (counted < RANDOM_ITEMS) begin
            if (counted >= next_reload) begin
                hold_until_drained();
                reload_coefficients();
                counted += N_COEF;
                next_reload += RELOAD_EVERY;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    c = write_cmd(MODE_NONE, $urandom, $urandom);
                    if (pick == 2) begin
                        c.mode = MODE_COEF;
                        c.index = INDEX_W'($urandom_range(N_COEF, MAX_INDEX));
                    end else if (pick == 3) begin
                        c.mode = MODE_STATE;
                        c.index = INDEX_W'($urandom_range(N_STATE, MAX_INDEX));
                    end
                    send_beat(c, next_gap());
                end else if (pick < 20) begin
                    idx = $urandom_range(0, N_COEF - 1);
                    send_beat(write_cmd(MODE_COEF, idx, coef_word(idx)), next_gap());
                    counted++;
                end else if (pick < 30) begin
                    idx = $urandom_range(0, N_STATE - 1);
                    send_beat(write_cmd(MODE_STATE, idx, rand_word(field_bits())),
                              next_gap());
                    counted++;
                end else begin
                    send_beat(step_cmd(rand_word(field_bits()), rand_word(field_bits()),
                                       rand_word(field_bits()), rand_word(field_bits()),
                                       rand_word(field_bits()), rand_word(field_bits()),
                                       rand_word(field_bits()), rand_word(field_bits())),
                              next_gap());
                    counted++;
                end
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
